FILE: hw/rtl/otra_pkg.sv
`timescale 1ns / 1ps
// otra_pkg: shared widths, codes, constants and helper functions of the over-temperature alarm
package otra_pkg;

    localparam int FUNC_W     = 3;
    localparam int TIME_W     = 32;
    localparam int TEMP_W     = 14;
    localparam int ROR_W      = 15;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    // operation codes carried by an input item
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE  = 3'd0,
        FUNC_TICK    = 3'd1,
        FUNC_RECOVER = 3'd2,
        FUNC_WARN    = 3'd3,
        FUNC_RESTART = 3'd4
    } t_func;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CRITICAL = 1'b0,
        REG_DANGER   = 1'b1
    } t_reg;

    // 15.0 C recovery margin below the danger level, in tenths
    localparam logic signed [TEMP_W:0]   SAFE_MARGIN  = 15'sd150;
    // recovery window length in ms
    localparam logic [TIME_W-1:0]        WINDOW_MS    = 32'd30000;
    localparam logic signed [TEMP_W-1:0] CRIT_RESET   = 14'sd2600;
    localparam logic signed [TEMP_W-1:0] DANGER_RESET = 14'sd2400;

    // one beep sequence step
    typedef struct packed {
        logic             fire;
        logic             tone;
        logic [CNT_W-1:0] count;
    } t_beep;

    // quotient by a constant through its reciprocal 2^32 + mlow, scaled by 2^shift
    function automatic logic [TIME_W-1:0] recip_quot(
        input logic [TIME_W-1:0] e,
        input logic [TIME_W-1:0] mlow,
        input int unsigned       shift
    );
        logic [2*TIME_W-1:0] prod;
        logic [2*TIME_W:0]   acc;
        prod = 64'(e) * 64'(mlow);
        acc  = {1'b0, e, 32'd0} + {1'b0, prod};
        return TIME_W'(acc >> shift);
    endfunction

    // advance a beep count from the current phase, saturating at max
    function automatic t_beep beep_step(
        input logic [TIME_W-1:0] phase,
        input logic [CNT_W-1:0]  count,
        input logic [CNT_W-1:0]  max
    );
        t_beep b;
        b.fire  = phase > {23'd0, count, 1'b0};
        b.tone  = b.fire & ~phase[0];
        b.count = count;
        if (b.fire) begin
            b.count = ({1'b0, phase[TIME_W-1:1]} > {24'd0, max}) ? max : phase[CNT_W:1];
        end
        return b;
    endfunction

endpackage

FILE: hw/rtl/otra_in_if.sv
`timescale 1ns / 1ps
// otra_in_if: input item channel of the over-temperature alarm
interface otra_in_if
    import otra_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [TIME_W-1:0]        now_ms;
    logic signed [TEMP_W-1:0] temperature;
    logic signed [ROR_W-1:0]  rate_of_rise;

    modport source (output valid, func, now_ms, temperature, rate_of_rise, input ready);
    modport sink   (input valid, func, now_ms, temperature, rate_of_rise, output ready);
endinterface

FILE: hw/rtl/otra_out_if.sv
`timescale 1ns / 1ps
// otra_out_if: result item channel of the over-temperature alarm
interface otra_out_if
    import otra_pkg::*;
;
    logic valid;
    logic ready;
    logic emergency_on;
    logic recovery_ready;
    logic window_open;
    logic trip_pulse;
    logic recovery_done;
    logic alarm_tone;
    logic warn_tone;

    modport source (
        output valid, emergency_on, recovery_ready, window_open, trip_pulse,
               recovery_done, alarm_tone, warn_tone,
        input  ready
    );
    modport sink (
        input  valid, emergency_on, recovery_ready, window_open, trip_pulse,
               recovery_done, alarm_tone, warn_tone,
        output ready
    );
endinterface

FILE: hw/rtl/overtemp_trip_recovery_alarm_unit.sv
`timescale 1ns / 1ps
// overtemp_trip_recovery_alarm_unit: over-temperature interlock with recovery window and beeps
//
// Each accepted item is held in an input register, evaluated against the latch, window
// and beep state, and its result lands in an output register, so one item is taken
// every clock while the result side keeps up. The input side stays ready while the
// output register is empty or being drained. The longest path is the beep phase:
// elapsed time times the constant reciprocal of the beep period (one 32 x 32 multiply
// and a 65-bit add per sequence) followed by the count compare. The user must write
// thresholds through the plain write port only while no item is in flight; the block
// does not enforce it, and there is no clearing pass after reset.
module overtemp_trip_recovery_alarm_unit
    import otra_pkg::*;
#(
    parameter int ALARM_BEEPS     = 5,
    parameter int WARN_BEEPS      = 3,
    parameter int ALARM_PERIOD_MS = 500,
    parameter int WARN_PERIOD_MS  = 300
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    otra_in_if.sink               i_in,
    otra_out_if.source            o_out
);

    // reciprocal constants of the two beep periods
    localparam int unsigned     A_SHIFT = 32 + $clog2(ALARM_PERIOD_MS);
    localparam longint unsigned A_MULT  =
        ((64'd1 << A_SHIFT) + 64'(ALARM_PERIOD_MS) - 64'd1) / 64'(ALARM_PERIOD_MS);
    localparam logic [TIME_W-1:0] A_MLOW = 32'(A_MULT);
    localparam int unsigned     W_SHIFT = 32 + $clog2(WARN_PERIOD_MS);
    localparam longint unsigned W_MULT  =
        ((64'd1 << W_SHIFT) + 64'(WARN_PERIOD_MS) - 64'd1) / 64'(WARN_PERIOD_MS);
    localparam logic [TIME_W-1:0] W_MLOW = 32'(W_MULT);
    localparam logic [CNT_W-1:0]  A_MAX  = 8'(ALARM_BEEPS);
    localparam logic [CNT_W-1:0]  W_MAX  = 8'(WARN_BEEPS);

    // input register
    logic                     r_in_valid;
    logic [FUNC_W-1:0]        r_in_func;
    logic [TIME_W-1:0]        r_in_now;
    logic signed [TEMP_W-1:0] r_in_temp;
    logic signed [ROR_W-1:0]  r_in_ror;

    // configuration
    logic signed [TEMP_W-1:0] r_crit;
    logic signed [TEMP_W-1:0] r_dang;

    // interlock and beep state
    logic              r_em,          n_em;
    logic              r_ro,          n_ro;
    logic              r_wr,          n_wr;
    logic [TIME_W-1:0] r_win_start,   n_win_start;
    logic [TIME_W-1:0] r_alarm_start, n_alarm_start;
    logic [CNT_W-1:0]  r_alarm_cnt,   n_alarm_cnt;
    logic              r_warn_act,    n_warn_act;
    logic [TIME_W-1:0] r_warn_start,  n_warn_start;
    logic [CNT_W-1:0]  r_warn_cnt,    n_warn_cnt;

    // output register
    logic r_out_valid;
    logic r_out_em, r_out_ro, r_out_wr, r_out_trip, r_out_done, r_out_atone, r_out_wtone;

    logic advance;
    logic trip, done, atone, wtone;
    logic temp_ge_crit, temp_ge_dang, temp_lt_safe, ror_neg;
    logic signed [TEMP_W:0] safe_lim;
    logic [TIME_W-1:0] a_phase, w_phase;
    t_beep             a_beep, w_beep;

    // handshake: an item moves on when the output register is free or being taken
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // input register load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_func <= i_in.func;
            r_in_now  <= i_in.now_ms;
            r_in_temp <= i_in.temperature;
            r_in_ror  <= i_in.rate_of_rise;
        end
    end

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crit <= CRIT_RESET;
            r_dang <= DANGER_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_CRITICAL: r_crit <= $signed(i_cfg_data);
                REG_DANGER:   r_dang <= $signed(i_cfg_data);
            endcase
        end
    end

    // temperature compares
    assign safe_lim     = $signed({r_dang[TEMP_W-1], r_dang}) - SAFE_MARGIN;
    assign temp_ge_crit = r_in_temp >= r_crit;
    assign temp_ge_dang = r_in_temp >= r_dang;
    assign temp_lt_safe = $signed({r_in_temp[TEMP_W-1], r_in_temp}) < safe_lim;
    assign ror_neg      = r_in_ror[ROR_W-1];

    // beep phases from elapsed time
    assign a_phase = recip_quot(r_in_now - r_alarm_start, A_MLOW, A_SHIFT);
    assign w_phase = recip_quot(r_in_now - r_warn_start, W_MLOW, W_SHIFT);
    assign a_beep  = beep_step(a_phase, r_alarm_cnt, A_MAX);
    assign w_beep  = beep_step(w_phase, r_warn_cnt, W_MAX);

    // next state and result of the held item
    always_comb begin
        n_em          = r_em;
        n_ro          = r_ro;
        n_wr          = r_wr;
        n_win_start   = r_win_start;
        n_alarm_start = r_alarm_start;
        n_alarm_cnt   = r_alarm_cnt;
        n_warn_act    = r_warn_act;
        n_warn_start  = r_warn_start;
        n_warn_cnt    = r_warn_cnt;
        trip          = 1'b0;
        done          = 1'b0;
        atone         = 1'b0;
        wtone         = 1'b0;
        unique case (t_func'(r_in_func))
            FUNC_SAMPLE: begin
                // trip latch
                if (temp_ge_crit && !r_em) begin
                    n_em          = 1'b1;
                    n_alarm_start = r_in_now;
                    n_alarm_cnt   = '0;
                    trip          = 1'b1;
                end
                // cooled down and falling: offer recovery
                if (n_em && !r_ro && temp_lt_safe && ror_neg) begin
                    n_ro        = 1'b1;
                    n_win_start = r_in_now;
                    n_wr        = 1'b1;
                end
                // window timeout
                if (n_wr && ((r_in_now - n_win_start) > WINDOW_MS)) begin
                    n_ro = 1'b0;
                    n_wr = 1'b0;
                end
                // reheated to the danger level
                if (n_ro && temp_ge_dang) begin
                    n_ro = 1'b0;
                    n_wr = 1'b0;
                end
            end
            FUNC_TICK: begin
                if (r_em && (r_alarm_cnt < A_MAX)) begin
                    atone       = a_beep.tone;
                    n_alarm_cnt = a_beep.count;
                end
                if (r_warn_act && (r_warn_cnt < W_MAX)) begin
                    wtone      = w_beep.tone;
                    n_warn_cnt = w_beep.count;
                    if (w_beep.count >= W_MAX) begin
                        n_warn_act = 1'b0;
                    end
                end
            end
            FUNC_RECOVER: begin
                if (r_ro && r_em) begin
                    n_em        = 1'b0;
                    n_alarm_cnt = A_MAX;
                    n_ro        = 1'b0;
                    n_wr        = 1'b0;
                    n_warn_act  = 1'b0;
                    n_warn_cnt  = W_MAX;
                    done        = 1'b1;
                end
            end
            FUNC_WARN: begin
                n_warn_act   = 1'b1;
                n_warn_start = r_in_now;
                n_warn_cnt   = '0;
            end
            FUNC_RESTART: begin
                if (r_em && (r_alarm_cnt < A_MAX)) begin
                    n_alarm_start = r_in_now;
                    n_alarm_cnt   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // state update as each item passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em          <= 1'b0;
            r_ro          <= 1'b0;
            r_wr          <= 1'b0;
            r_win_start   <= '0;
            r_alarm_start <= '0;
            r_alarm_cnt   <= '0;
            r_warn_act    <= 1'b0;
            r_warn_start  <= '0;
            r_warn_cnt    <= '0;
        end else if (advance) begin
            r_em          <= n_em;
            r_ro          <= n_ro;
            r_wr          <= n_wr;
            r_win_start   <= n_win_start;
            r_alarm_start <= n_alarm_start;
            r_alarm_cnt   <= n_alarm_cnt;
            r_warn_act    <= n_warn_act;
            r_warn_start  <= n_warn_start;
            r_warn_cnt    <= n_warn_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_em    <= n_em;
            r_out_ro    <= n_ro;
            r_out_wr    <= n_wr;
            r_out_trip  <= trip;
            r_out_done  <= done;
            r_out_atone <= atone;
            r_out_wtone <= wtone;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.emergency_on   = r_out_em;
    assign o_out.recovery_ready = r_out_ro;
    assign o_out.window_open    = r_out_wr;
    assign o_out.trip_pulse     = r_out_trip;
    assign o_out.recovery_done  = r_out_done;
    assign o_out.alarm_tone     = r_out_atone;
    assign o_out.warn_tone      = r_out_wtone;

endmodule

FILE: hw/rtl/otra_checker.sv
`timescale 1ns / 1ps
// otra_checker: port-level assertions for the over-temperature alarm, bound to the top level
module otra_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_emergency_on,
    input logic i_recovery_ready,
    input logic i_window_open,
    input logic i_trip_pulse,
    input logic i_recovery_done,
    input logic i_alarm_tone,
    input logic i_warn_tone
);

    logic r_seen;
    logic r_last_em;

    // latch state of the last delivered item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= 1'b0;
            r_last_em <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_seen    <= 1'b1;
            r_last_em <= i_emergency_on;
        end
    end

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // input side stays open unless the result side is stalled
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_out_valid && !i_out_ready) |-> i_in_ready)
        else $error("input not ready while output is free");

    // emergency clears only through an accepted recovery
    a_em_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen && r_last_em && !i_emergency_on |-> i_recovery_done)
        else $error("emergency dropped without recovery");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_emergency_on)
            && $stable(i_recovery_ready) && $stable(i_window_open) && $stable(i_trip_pulse)
            && $stable(i_recovery_done) && $stable(i_alarm_tone) && $stable(i_warn_tone))
        else $error("stalled result changed");

endmodule

bind overtemp_trip_recovery_alarm_unit otra_checker u_otra_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_emergency_on   (o_out.emergency_on),
    .i_recovery_ready (o_out.recovery_ready),
    .i_window_open    (o_out.window_open),
    .i_trip_pulse     (o_out.trip_pulse),
    .i_recovery_done  (o_out.recovery_done),
    .i_alarm_tone     (o_out.alarm_tone),
    .i_warn_tone      (o_out.warn_tone)
);

FILE: tb/sv/overtemp_trip_recovery_alarm_unit_test.sv
`timescale 1ns / 1ps
// overtemp_trip_recovery_alarm_unit_test: self-checking bench with a scoreboard class for the alarm unit
module overtemp_trip_recovery_alarm_unit_test
    import otra_pkg::*;
;

    localparam int ALARM_BEEPS     = 5;
    localparam int WARN_BEEPS      = 3;
    localparam int ALARM_PERIOD_MS = 500;
    localparam int WARN_PERIOD_MS  = 300;

    // 15.0 C margin in tenths, window length in ms
    localparam int              SAFE_MARGIN_T  = 150;
    localparam logic [TIME_W-1:0] WINDOW_LEN_MS = 32'd30000;

    localparam int NUM_PHASES       = 8;
    localparam int ITEMS_PER_PHASE  = 228;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int MAX_SHOWN        = 40;

    // func codes the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [TIME_W-1:0]        now_ms;
        logic signed [TEMP_W-1:0] temperature;
        logic signed [ROR_W-1:0]  rate_of_rise;
    } t_in_item;

    typedef struct packed {
        logic emergency_on;
        logic recovery_ready;
        logic window_open;
        logic trip_pulse;
        logic recovery_done;
        logic alarm_tone;
        logic warn_tone;
    } t_flags;

    // interlock state, thresholds and the flags each accepted item should produce
    class interlock_model;
        int                critical = 2600;
        int                danger   = 2400;
        bit                latched;
        bit                offered;
        bit                window_on;
        logic [TIME_W-1:0] window_t0;
        logic [TIME_W-1:0] alarm_t0;
        logic [TIME_W-1:0] warn_t0;
        int unsigned       alarm_cnt;
        int unsigned       warn_cnt;
        bit                warn_on;
        t_flags            expected_flags[$];
        int                errors;
        int                shown;

        function void set_thresholds(logic signed [TEMP_W-1:0] crit,
                                     logic signed [TEMP_W-1:0] dang);
            critical = crit;
            danger   = dang;
        endfunction

        // one beep sequence: count follows whole double periods, saturated
        function bit advance_beeps(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] start,
                                   input int unsigned period,
                                   input int unsigned limit,
                                   inout int unsigned count);
            logic [TIME_W-1:0] phase;
            bit                tone;
            phase = (now - start) / period;
            tone  = 1'b0;
            if (phase > count * 2) begin
                tone  = ~phase[0];
                count = (phase / 2 > limit) ? limit : phase / 2;
            end
            return tone;
        endfunction

        function void accept_item(t_in_item it);
            int     t;
            int     r;
            t_flags f;
            t = $signed(it.temperature);
            r = $signed(it.rate_of_rise);
            f = '0;
            case (it.func)
                FUNC_SAMPLE: begin
                    if (t >= critical && !latched) begin
                        latched   = 1'b1;
                        alarm_t0  = it.now_ms;
                        alarm_cnt = 0;
                        f.trip_pulse = 1'b1;
                    end
                    // cooling with a falling rate opens the window
                    if (latched && !offered && t < danger - SAFE_MARGIN_T && r < 0) begin
                        offered   = 1'b1;
                        window_on = 1'b1;
                        window_t0 = it.now_ms;
                    end
                    if (window_on && (it.now_ms - window_t0) > WINDOW_LEN_MS) begin
                        offered   = 1'b0;
                        window_on = 1'b0;
                    end
                    if (offered && t >= danger) begin
                        offered   = 1'b0;
                        window_on = 1'b0;
                    end
                end
                FUNC_TICK: begin
                    if (latched && alarm_cnt < ALARM_BEEPS)
                        f.alarm_tone = advance_beeps(it.now_ms, alarm_t0, ALARM_PERIOD_MS,
                                                     ALARM_BEEPS, alarm_cnt);
                    if (warn_on && warn_cnt < WARN_BEEPS) begin
                        f.warn_tone = advance_beeps(it.now_ms, warn_t0, WARN_PERIOD_MS,
                                                    WARN_BEEPS, warn_cnt);
                        if (warn_cnt >= WARN_BEEPS)
                            warn_on = 1'b0;
                    end
                end
                FUNC_RECOVER: begin
                    if (offered && latched) begin
                        latched   = 1'b0;
                        offered   = 1'b0;
                        window_on = 1'b0;
                        warn_on   = 1'b0;
                        alarm_cnt = ALARM_BEEPS;
                        warn_cnt  = WARN_BEEPS;
                        f.recovery_done = 1'b1;
                    end
                end
                FUNC_WARN: begin
                    warn_on  = 1'b1;
                    warn_t0  = it.now_ms;
                    warn_cnt = 0;
                end
                FUNC_RESTART: begin
                    if (latched && alarm_cnt < ALARM_BEEPS) begin
                        alarm_t0  = it.now_ms;
                        alarm_cnt = 0;
                    end
                end
                default: ;
            endcase
            f.emergency_on   = latched;
            f.recovery_ready = offered;
            f.window_open    = window_on;
            expected_flags.push_back(f);
        endfunction

        function void compare_field(string name, logic want, logic got);
            if (got !== want) begin
                errors++;
                if (shown < MAX_SHOWN) begin
                    shown++;
                    $display("%0t mismatch %s: expected %0b, actual %0b", $time, name, want, got);
                end
            end
        endfunction

        function void check_flags(t_flags got);
            t_flags want;
            if (expected_flags.size() == 0) begin
                errors++;
                if (shown < MAX_SHOWN) begin
                    shown++;
                    $display("%0t unexpected result: expected none, actual %b", $time, got);
                end
                return;
            end
            want = expected_flags.pop_front();
            compare_field("emergency_on", want.emergency_on, got.emergency_on);
            compare_field("recovery_ready", want.recovery_ready, got.recovery_ready);
            compare_field("window_open", want.window_open, got.window_open);
            compare_field("trip_pulse", want.trip_pulse, got.trip_pulse);
            compare_field("recovery_done", want.recovery_done, got.recovery_done);
            compare_field("alarm_tone", want.alarm_tone, got.alarm_tone);
            compare_field("warn_tone", want.warn_tone, got.warn_tone);
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    otra_in_if  in_ch ();
    otra_out_if out_ch ();

    interlock_model    interlock;
    bit                idle_on;
    bit                long_hold_req;
    int                rx_stall_left;
    int                stuck_cycles;
    logic [TIME_W-1:0] clock_ms;

    overtemp_trip_recovery_alarm_unit #(
        .ALARM_BEEPS     (ALARM_BEEPS),
        .WARN_BEEPS      (WARN_BEEPS),
        .ALARM_PERIOD_MS (ALARM_PERIOD_MS),
        .WARN_PERIOD_MS  (WARN_PERIOD_MS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check accepted items, stall in random bursts or one long hold
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                interlock.check_flags('{out_ch.emergency_on, out_ch.recovery_ready,
                                        out_ch.window_open, out_ch.trip_pulse,
                                        out_ch.recovery_done, out_ch.alarm_tone,
                                        out_ch.warn_tone});
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rx_stall_left = LONG_HOLD_CYCLES;
            end else if (rx_stall_left == 0 && idle_on && $urandom_range(0, 99) < 10) begin
                rx_stall_left = $urandom_range(1, 17);
            end
            if (rx_stall_left > 0) begin
                out_ch.ready <= 1'b0;
                rx_stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic t_in_item mk_item(logic [FUNC_W-1:0] f, logic [TIME_W-1:0] now,
                                         int temp, int ror);
        t_in_item it;
        it.func         = f;
        it.now_ms       = now;
        it.temperature  = temp[TEMP_W-1:0];
        it.rate_of_rise = ror[ROR_W-1:0];
        return it;
    endfunction

    // offer one item, optionally after a random gap; valid stays high on return
    task automatic drive_item(t_in_item it);
        int gap;
        if (idle_on && $urandom_range(0, 99) < 12) begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.func         <= it.func;
        in_ch.now_ms       <= it.now_ms;
        in_ch.temperature  <= it.temperature;
        in_ch.rate_of_rise <= it.rate_of_rise;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        interlock.accept_item(it);
    endtask

    // both thresholds, back to back
    task automatic write_regs(int crit, int dang);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_CRITICAL;
        i_cfg_data <= crit[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_idx  <= REG_DANGER;
        i_cfg_data <= dang[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        interlock.set_thresholds(crit[TEMP_W-1:0], dang[TEMP_W-1:0]);
    endtask

    // drop valid and wait for the block to drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (interlock.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // trip, beeps, window edges, recovery and unused codes at default thresholds
    task automatic run_directed();
        idle_on = 1'b1;
        drive_item(mk_item(FUNC_SPARE_A, 32'd0, 0, 0));
        drive_item(mk_item(FUNC_TICK, 32'd500, 100, 0));
        drive_item(mk_item(FUNC_RECOVER, 32'd600, 0, -3));
        drive_item(mk_item(FUNC_RESTART, 32'd700, 0, 0));
        drive_item(mk_item(FUNC_SAMPLE, 32'd1000, 2599, 10000));
        drive_item(mk_item(FUNC_SAMPLE, 32'd2000, 2600, 5));
        drive_item(mk_item(FUNC_SAMPLE, 32'd2001, 2600, 5));
        drive_item(mk_item(FUNC_TICK, 32'd2000, 0, 0));
        drive_item(mk_item(FUNC_TICK, 32'd2500, 0, 0));
        drive_item(mk_item(FUNC_TICK, 32'd3000, 0, 0));
        drive_item(mk_item(FUNC_RESTART, 32'd3100, 0, 0));
        drive_item(mk_item(FUNC_WARN, 32'd3200, 0, 0));
        drive_item(mk_item(FUNC_TICK, 32'd3800, 0, 0));
        drive_item(mk_item(FUNC_RECOVER, 32'd4000, 0, 0));
        // margin boundary and zero rate
        drive_item(mk_item(FUNC_SAMPLE, 32'd5000, 2249, 0));
        drive_item(mk_item(FUNC_SAMPLE, 32'd6000, 2250, -1));
        drive_item(mk_item(FUNC_SAMPLE, 32'd10000, 2249, -1));
        // window still open at exactly 30 s, closed one ms later
        drive_item(mk_item(FUNC_SAMPLE, 32'd40000, 2300, -10000));
        drive_item(mk_item(FUNC_SAMPLE, 32'd40001, 2300, -10000));
        // reopen, then close by climbing back to danger
        drive_item(mk_item(FUNC_SAMPLE, 32'd50000, -500, -10000));
        drive_item(mk_item(FUNC_SAMPLE, 32'd50010, 2400, 10000));
        drive_item(mk_item(FUNC_SAMPLE, 32'd60000, -500, -5));
        // long gap saturates both beep counts
        drive_item(mk_item(FUNC_TICK, 32'hFFFF_FF00, 0, 0));
        drive_item(mk_item(FUNC_RECOVER, 32'hFFFF_FFFF, 5000, 10000));
        drive_item(mk_item(FUNC_SAMPLE, 32'd100, 5000, 10000));
        drive_item(mk_item(FUNC_SPARE_C, 32'd200, -500, -10000));
        clock_ms = 32'd200;
    endtask

    // random items with advancing time, temperatures clustered at the thresholds
    task automatic run_random(int count, bit quiet);
        int                n;
        int                t;
        int                r;
        int                sel;
        logic [FUNC_W-1:0] f;
        n = 0;
        while (n < count) begin
            idle_on = !quiet && ((n / 60) % 4 != 3);
            sel = $urandom_range(0, 19);
            if (sel < 14)
                clock_ms += $urandom_range(0, 700);
            else if (sel < 18)
                clock_ms += $urandom_range(0, 3000);
            else if (sel < 19)
                clock_ms += $urandom_range(20000, 40000);
            else
                clock_ms += $urandom;

            sel = $urandom_range(0, 9);
            if (sel < 3)
                t = interlock.critical + int'($urandom_range(0, 60)) - 30;
            else if (sel < 6)
                t = interlock.danger - SAFE_MARGIN_T + int'($urandom_range(0, 60)) - 30;
            else if (sel < 7)
                t = interlock.danger + int'($urandom_range(0, 40)) - 20;
            else
                t = int'($urandom_range(0, 5500)) - 500;
            if (t < -500)
                t = -500;
            if (t > 5000)
                t = 5000;

            sel = $urandom_range(0, 9);
            if (sel < 7)
                r = int'($urandom_range(0, 200)) - 100;
            else if (sel < 9)
                r = int'($urandom_range(0, 20000)) - 10000;
            else
                r = $urandom_range(0, 1) ? 10000 : -10000;

            sel = $urandom_range(0, 99);
            if (sel < 45)
                f = FUNC_SAMPLE;
            else if (sel < 75)
                f = FUNC_TICK;
            else if (sel < 84)
                f = FUNC_RECOVER;
            else if (sel < 90)
                f = FUNC_WARN;
            else if (sel < 96)
                f = FUNC_RESTART;
            else begin
                case ($urandom_range(0, 2))
                    0: f = FUNC_SPARE_A;
                    1: f = FUNC_SPARE_B;
                    default: f = FUNC_SPARE_C;
                endcase
            end

            drive_item(mk_item(f, clock_ms, t, r));
            if (f <= FUNC_RESTART)
                n++;
        end
    endtask

    initial begin
        int crit_tab[NUM_PHASES];
        int dang_tab[NUM_PHASES];
        int p;

        crit_tab = '{2600, -500, 5000, 1000, 5000, -500, 0, 2600};
        dang_tab = '{2400, -500, 5000, 1300, -500, 5000, 0, 2400};
        crit_tab[6] = int'($urandom_range(0, 5500)) - 500;
        dang_tab[6] = int'($urandom_range(0, 5500)) - 500;

        interlock = new();
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = REG_CRITICAL;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.func         = FUNC_SAMPLE;
        in_ch.now_ms       = '0;
        in_ch.temperature  = '0;
        in_ch.rate_of_rise = '0;
        out_ch.ready       = 1'b0;
        clock_ms           = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (p = 0; p < NUM_PHASES; p++) begin
            write_regs(crit_tab[p], dang_tab[p]);
            if (p == 0)
                run_directed();
            // fill the block while results are held off
            if (p == 1)
                long_hold_req = 1'b1;
            // let time wrap through zero
            if (p == 3)
                clock_ms = 32'hFFFF_4000;
            run_random(ITEMS_PER_PHASE, p == NUM_PHASES - 1);
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (interlock.errors == 0 && interlock.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
